// File: hdl/rkm_pkg.sv
// ----------------------------------------------------------------------------
// rkm_pkg
// Shared constants and types for the RSA key derivation and exponent core.
// ----------------------------------------------------------------------------
package rkm_pkg;

  localparam int PRIME_BITS = 16;
  localparam logic [15:0] PRIME_MASK = 16'((32'd1 << PRIME_BITS) - 32'd1);

  localparam logic [1:0] REG_PRIME_P = 2'd0;
  localparam logic [1:0] REG_PRIME_Q = 2'd1;

  localparam logic [15:0] PRIME_P_RESET = 16'd61 & PRIME_MASK;
  localparam logic [15:0] PRIME_Q_RESET = 16'd53 & PRIME_MASK;

  localparam logic [31:0] FIRST_EXPONENT = 32'd3;
  localparam logic [31:0] EXPONENT_STEP  = 32'd2;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quotient;
    logic [31:0] remainder;
  } div_resp_t;

endpackage

// File: hdl/rkm_divider.sv
// ----------------------------------------------------------------------------
// rkm_divider
// Restoring 64 by 32 bit divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rkm_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rkm_pkg::div_req_t  req,
  output rkm_pkg::div_resp_t resp
);
  import rkm_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] dvd_r, dvd_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] dsr_r, dsr_nxt;
  logic [32:0] shifted;
  logic [32:0] diff;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    shifted  = {rem_r, dvd_r[63]};
    diff     = shifted - {1'b0, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        dvd_nxt = {dvd_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted[31:0];
        dvd_nxt = {dvd_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign resp.busy      = busy_r;
  assign resp.done      = done_r;
  assign resp.quotient  = dvd_r;
  assign resp.remainder = rem_r;

endmodule

// File: hdl/rsa_keygen_modexp_core.sv
// ----------------------------------------------------------------------------
// rsa_keygen_modexp_core
// Textbook RSA engine: derives n, e and d from two small primes and raises
// each input value to e or d modulo n.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall is high from the transfer until the
// result is loaded into the output register. Every reduction (base mod n,
// each modular multiply, each gcd and Euclid step) runs through one shared
// restoring divider, and an item with a 32-bit exponent takes up to about 64
// multiplies. The first item after reset or a prime write also runs key
// derivation first: a gcd search for e and extended Euclid for d, each step
// one divider pass.
module rsa_keygen_modexp_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_result_value,
  output logic [31:0] out_modulus,
  output logic [31:0] out_public_exponent,
  output logic [31:0] out_private_exponent
);
  import rkm_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_KEY_INIT  = 16'h0002,
    S_GCD_SETUP = 16'h0004,
    S_GCD_LOOP  = 16'h0008,
    S_GCD_WAIT  = 16'h0010,
    S_INV_SETUP = 16'h0020,
    S_INV_LOOP  = 16'h0040,
    S_INV_WAIT  = 16'h0080,
    S_INV_UPD   = 16'h0100,
    S_EXP_START = 16'h0200,
    S_BASE_WAIT = 16'h0400,
    S_EXP_LOOP  = 16'h0800,
    S_MUL_WAIT  = 16'h1000,
    S_EXP_SQ    = 16'h2000,
    S_SQ_WAIT   = 16'h4000,
    S_DONE      = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] p_r, p_nxt, q_r, q_nxt;
  logic        kv_r, kv_nxt;
  logic [31:0] n_r, n_nxt, e_r, e_nxt, d_r, d_nxt, phi_r, phi_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt, qt_r, qt_nxt;
  logic signed [33:0] x0_r, x0_nxt, x1_r, x1_nxt, x1_wrap;
  logic        kind_r, kind_nxt;
  logic [31:0] val_r, val_nxt, ex_r, ex_nxt, base_r, base_nxt, acc_r, acc_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] ores_r, ores_nxt, on_r, on_nxt, oe_r, oe_nxt, od_r, od_nxt;
  logic [15:0] pm, qm;
  logic [31:0] mul_a, mul_b;
  logic [63:0] product;
  div_req_t    dreq;
  div_resp_t   dresp;

  rkm_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .resp (dresp)
  );

  assign pm      = (p_r == 16'd0) ? 16'd0 : p_r - 16'd1;
  assign qm      = (q_r == 16'd0) ? 16'd0 : q_r - 16'd1;
  assign product = 64'(mul_a) * 64'(mul_b);
  assign x1_wrap = x1_r + $signed({2'b00, phi_r});

  always_comb begin
    state_nxt = state_r;
    p_nxt = p_r;  q_nxt = q_r;  kv_nxt = kv_r;
    n_nxt = n_r;  e_nxt = e_r;  d_nxt = d_r;  phi_nxt = phi_r;
    a_nxt = a_r;  b_nxt = b_r;  qt_nxt = qt_r;
    x0_nxt = x0_r;  x1_nxt = x1_r;
    kind_nxt = kind_r;  val_nxt = val_r;  ex_nxt = ex_r;
    base_nxt = base_r;  acc_nxt = acc_r;
    ores_nxt = ores_r;  on_nxt = on_r;  oe_nxt = oe_r;  od_nxt = od_r;
    ov_nxt = ov_r & out_stall;
    mul_a = acc_r;
    mul_b = base_r;
    dreq.start    = 1'b0;
    dreq.dividend = product;
    dreq.divisor  = n_r;

    if (cfg_we) begin
      if (cfg_index == REG_PRIME_P) begin
        p_nxt  = cfg_data & PRIME_MASK;
        kv_nxt = 1'b0;
      end else if (cfg_index == REG_PRIME_Q) begin
        q_nxt  = cfg_data & PRIME_MASK;
        kv_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          val_nxt   = in_value;
          state_nxt = kv_r ? S_EXP_START : S_KEY_INIT;
        end
      end
      S_KEY_INIT: begin
        n_nxt   = 32'(p_r) * 32'(q_r);
        phi_nxt = 32'(pm) * 32'(qm);
        e_nxt   = FIRST_EXPONENT;
        if (pm == 16'd0 || qm == 16'd0) begin
          d_nxt     = '0;
          kv_nxt    = 1'b1;
          state_nxt = S_EXP_START;
        end else begin
          state_nxt = S_GCD_SETUP;
        end
      end
      S_GCD_SETUP: begin
        a_nxt     = e_r;
        b_nxt     = phi_r;
        state_nxt = S_GCD_LOOP;
      end
      S_GCD_LOOP: begin
        if (b_r == 32'd0) begin
          if (a_r == 32'd1) begin
            state_nxt = S_INV_SETUP;
          end else begin
            e_nxt     = e_r + EXPONENT_STEP;
            state_nxt = S_GCD_SETUP;
          end
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = {32'd0, a_r};
          dreq.divisor  = b_r;
          state_nxt     = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (dresp.done) begin
          a_nxt     = b_r;
          b_nxt     = dresp.remainder;
          state_nxt = S_GCD_LOOP;
        end
      end
      S_INV_SETUP: begin
        a_nxt     = e_r;
        b_nxt     = phi_r;
        x0_nxt    = 34'sd0;
        x1_nxt    = 34'sd1;
        state_nxt = S_INV_LOOP;
      end
      S_INV_LOOP: begin
        if (a_r > 32'd1 && b_r != 32'd0) begin
          dreq.start    = 1'b1;
          dreq.dividend = {32'd0, a_r};
          dreq.divisor  = b_r;
          state_nxt     = S_INV_WAIT;
        end else begin
          d_nxt     = x1_r[33] ? x1_wrap[31:0] : x1_r[31:0];
          kv_nxt    = 1'b1;
          state_nxt = S_EXP_START;
        end
      end
      S_INV_WAIT: begin
        if (dresp.done) begin
          qt_nxt    = dresp.quotient[31:0];
          a_nxt     = b_r;
          b_nxt     = dresp.remainder;
          state_nxt = S_INV_UPD;
        end
      end
      S_INV_UPD: begin
        x0_nxt    = x1_r - $signed({2'b00, qt_r}) * x0_r;
        x1_nxt    = x0_r;
        state_nxt = S_INV_LOOP;
      end
      S_EXP_START: begin
        ex_nxt = kind_r ? d_r : e_r;
        if (n_r == 32'd0) begin
          acc_nxt   = '0;
          state_nxt = S_DONE;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = {32'd0, val_r};
          state_nxt     = S_BASE_WAIT;
        end
      end
      S_BASE_WAIT: begin
        if (dresp.done) begin
          base_nxt  = dresp.remainder;
          acc_nxt   = 32'd1;
          state_nxt = S_EXP_LOOP;
        end
      end
      S_EXP_LOOP: begin
        if (ex_r == 32'd0) begin
          state_nxt = S_DONE;
        end else if (ex_r[0]) begin
          dreq.start = 1'b1;
          state_nxt  = S_MUL_WAIT;
        end else begin
          state_nxt = S_EXP_SQ;
        end
      end
      S_MUL_WAIT: begin
        if (dresp.done) begin
          acc_nxt   = dresp.remainder;
          state_nxt = S_EXP_SQ;
        end
      end
      S_EXP_SQ: begin
        ex_nxt = ex_r >> 1;
        mul_a  = base_r;
        if (ex_r[31:1] == 31'd0) begin
          state_nxt = S_EXP_LOOP;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = S_SQ_WAIT;
        end
      end
      S_SQ_WAIT: begin
        if (dresp.done) begin
          base_nxt  = dresp.remainder;
          state_nxt = S_EXP_LOOP;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          ores_nxt  = acc_r;
          on_nxt    = n_r;
          oe_nxt    = e_r;
          od_nxt    = d_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_r     <= PRIME_P_RESET;
      q_r     <= PRIME_Q_RESET;
      kv_r    <= 1'b0;
      n_r     <= '0;
      e_r     <= '0;
      d_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_r     <= p_nxt;
      q_r     <= q_nxt;
      kv_r    <= kv_nxt;
      n_r     <= n_nxt;
      e_r     <= e_nxt;
      d_r     <= d_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phi_r  <= phi_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    qt_r   <= qt_nxt;
    x0_r   <= x0_nxt;
    x1_r   <= x1_nxt;
    kind_r <= kind_nxt;
    val_r  <= val_nxt;
    ex_r   <= ex_nxt;
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
    ores_r <= ores_nxt;
    on_r   <= on_nxt;
    oe_r   <= oe_nxt;
    od_r   <= od_nxt;
  end

  assign in_stall             = (state_r != S_IDLE);
  assign out_valid            = ov_r;
  assign out_result_value     = ores_r;
  assign out_modulus          = on_r;
  assign out_public_exponent  = oe_r;
  assign out_private_exponent = od_r;

  // The shared divider is never restarted while a pass is running.
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !dresp.busy)
    else $error("divider started while busy");

  // A finished pass is only ever consumed by a state waiting for it.
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dresp.done |-> (state_r == S_GCD_WAIT || state_r == S_INV_WAIT ||
                    state_r == S_BASE_WAIT || state_r == S_MUL_WAIT ||
                    state_r == S_SQ_WAIT))
    else $error("divider result with no consumer");

  // A delivered public exponent is always odd.
  a_out_e_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_public_exponent[0])
    else $error("even public exponent delivered");

  // Checks that the keys-valid flag is set whenever the exponentiation starts.
  a_keys_before_exp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXP_START) |-> kv_r)
    else $error("exponentiation without derived keys");

endmodule
